// ----- hw/rtl/ucb_child_score_core_defines.svh -----
// ----------------------------------------------------------------------------
// UCB child score core: assertion macros
// Shared concurrent assertion wrappers, clocked on clk_i, off during reset.
// ----------------------------------------------------------------------------
`ifndef UCB_CHILD_SCORE_CORE_DEFINES_SVH
`define UCB_CHILD_SCORE_CORE_DEFINES_SVH

// Plain property check
`define UCBS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Antecedent in this cycle, consequent in the next one
`define UCBS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/ucbs_pkg.sv -----
// ----------------------------------------------------------------------------
// UCB child score package
// Widths, cell payload types and register indexes shared by the core.
// ----------------------------------------------------------------------------
`default_nettype none

package ucbs_pkg;

  // Field formats
  localparam int VISIT_BITS = 32;
  localparam int FRAC_BITS  = 16;
  localparam int GAIN_W     = 24;
  localparam int WGT_W      = 17;
  localparam int FRESH_W    = 24;
  localparam int PRIOR_W    = 17;
  localparam int MEAN_W     = 18;
  localparam int TV_W       = VISIT_BITS + FRAC_BITS;
  localparam int SCORE_W    = 40;

  // Config port
  localparam int CFG_DATA_W = 24;
  localparam int CFG_IDX_W  = 3;

  // Internal widths
  localparam int K_W       = $clog2(VISIT_BITS);
  localparam int SQ_ROOT_W = VISIT_BITS / 2 + FRAC_BITS;
  localparam int SQ_RAD_W  = 2 * SQ_ROOT_W;
  localparam int SQ_REM_W  = SQ_ROOT_W + 2;
  localparam int C_W       = GAIN_W + SQ_ROOT_W - FRAC_BITS;
  localparam int NUM_W     = C_W + PRIOR_W;
  localparam int Q_W       = NUM_W - FRAC_BITS;
  localparam int DV_W      = TV_W + 1;
  localparam int LN_W      = K_W + FRAC_BITS;
  localparam int RATIO_W   = LN_W + FRAC_BITS;
  localparam int RROOT_W   = (RATIO_W + 1) / 2;
  localparam int LOGT_W    = GAIN_W + RROOT_W - FRAC_BITS;
  localparam int LN2_W     = 32;

  // ln(2) in Q0.32
  localparam logic [LN2_W-1:0] LN2_Q32 = 32'd2977044472;
  // 1.0 in the blend weight format
  localparam logic [WGT_W-1:0] W_ONE = WGT_W'(1) << FRAC_BITS;

  // Square root cell payload: partial remainder, root so far, radicand bits left
  typedef struct packed {
    logic [SQ_REM_W-1:0]  rem;
    logic [SQ_ROOT_W-1:0] root;
    logic [SQ_RAD_W-1:0]  rad;
  } sq_t;

  // Log2 squaring cell payload: Q1.31 mantissa and fraction bits so far
  typedef struct packed {
    logic [VISIT_BITS-1:0] m;
    logic [FRAC_BITS-1:0]  frac;
  } lg_t;

  // Restoring divider cell payload
  typedef struct packed {
    logic [DV_W-1:0] rem;
    logic [Q_W-1:0]  dd;
    logic [Q_W-1:0]  q;
    logic [DV_W-1:0] dvs;
  } dv_t;

  // Config register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_EXPLORE_GAIN    = 3'd0,
    CFG_SCALE_BY_PARENT = 3'd1,
    CFG_LOSS_WEIGHT     = 3'd2,
    CFG_LOG_GAIN        = 3'd3,
    CFG_FRESH_VALUE     = 3'd4
  } cfg_idx_e;

endpackage

`default_nettype wire

// ----- hw/rtl/ucbs_sqrt_cell.sv -----
// ----------------------------------------------------------------------------
// UCB score square root cell
// One restoring square root step: takes one bit pair, yields one root bit.
// ----------------------------------------------------------------------------
`default_nettype none

module ucbs_sqrt_cell
  import ucbs_pkg::*;
(
  input  logic clk_i,
  input  sq_t  sq_i,
  output sq_t  sq_o
);

  logic [SQ_REM_W+1:0] rem2;
  logic [SQ_REM_W+1:0] trial;
  logic [SQ_REM_W+1:0] diff;
  logic                take;
  sq_t                 sq_d;
  sq_t                 sq_q;

  // Bring down the next pair and try 4*root+1
  always_comb begin
    rem2  = {sq_i.rem, sq_i.rad[SQ_RAD_W-1 -: 2]};
    trial = {2'b00, sq_i.root, 2'b01};
    diff  = rem2 - trial;
    take  = (rem2 >= trial);
    sq_d.rad  = {sq_i.rad[SQ_RAD_W-3:0], 2'b00};
    sq_d.rem  = take ? diff[SQ_REM_W-1:0] : rem2[SQ_REM_W-1:0];
    sq_d.root = {sq_i.root[SQ_ROOT_W-2:0], take};
  end

  always_ff @(posedge clk_i) begin
    sq_q <= sq_d;
  end

  assign sq_o = sq_q;

endmodule

`default_nettype wire

// ----- hw/rtl/ucbs_log_cell.sv -----
// ----------------------------------------------------------------------------
// UCB score log2 cell
// One squaring step of the bit-by-bit log2: yields one fraction bit.
// ----------------------------------------------------------------------------
`default_nettype none

module ucbs_log_cell
  import ucbs_pkg::*;
(
  input  logic clk_i,
  input  lg_t  lg_i,
  output lg_t  lg_o
);

  logic [2*VISIT_BITS-1:0] sq;
  logic [VISIT_BITS:0]     t;
  lg_t                     lg_d;
  lg_t                     lg_q;

  // Square the mantissa; renormalize when it reaches 2.0
  always_comb begin
    sq = (2*VISIT_BITS)'(lg_i.m) * (2*VISIT_BITS)'(lg_i.m);
    t  = sq[2*VISIT_BITS-1:VISIT_BITS-1];
    lg_d.m    = t[VISIT_BITS] ? t[VISIT_BITS:1] : t[VISIT_BITS-1:0];
    lg_d.frac = {lg_i.frac[FRAC_BITS-2:0], t[VISIT_BITS]};
  end

  always_ff @(posedge clk_i) begin
    lg_q <= lg_d;
  end

  assign lg_o = lg_q;

endmodule

`default_nettype wire

// ----- hw/rtl/ucbs_div_cell.sv -----
// ----------------------------------------------------------------------------
// UCB score divider cell
// One restoring division step: shifts in one dividend bit, yields one
// quotient bit; the divisor travels along with the item.
// ----------------------------------------------------------------------------
`default_nettype none

module ucbs_div_cell
  import ucbs_pkg::*;
(
  input  logic clk_i,
  input  dv_t  dv_i,
  output dv_t  dv_o
);

  logic [DV_W:0] r2;
  logic [DV_W:0] diff;
  logic          ge;
  dv_t           dv_d;
  dv_t           dv_q;

  // Remainder stays below the divisor, so one compare and subtract per bit
  always_comb begin
    r2   = {dv_i.rem, dv_i.dd[Q_W-1]};
    diff = r2 - {1'b0, dv_i.dvs};
    ge   = (r2 >= {1'b0, dv_i.dvs});
    dv_d.rem = ge ? diff[DV_W-1:0] : r2[DV_W-1:0];
    dv_d.dd  = {dv_i.dd[Q_W-2:0], 1'b0};
    dv_d.q   = {dv_i.q[Q_W-2:0], ge};
    dv_d.dvs = dv_i.dvs;
  end

  always_ff @(posedge clk_i) begin
    dv_q <= dv_d;
  end

  assign dv_o = dv_q;

endmodule

`default_nettype wire

// ----- hw/rtl/ucb_child_score_core.sv -----
// ----------------------------------------------------------------------------
// UCB child score core
// PUCT-style selection score for one parent/child edge per request.
// ----------------------------------------------------------------------------
// Takes one edge request per clock (busy_o stays low) and returns its score on
// score_o with a one-cycle done_o strobe; there is no back-pressure, so the
// receiver must take every score as it appears.
// The latency is set by the longest cell chain: a 32-cell square root of the
// parent count, a 41-cell divider for the exploration term, and in parallel
// a 16-cell log2, a 41-cell divider and a 19-cell square root for the log
// term. Config registers are written through cfg_we_i/cfg_idx_i/cfg_wdata_i
// and must only change while no request is in flight.
`default_nettype none

`include "ucb_child_score_core_defines.svh"

module ucb_child_score_core
  import ucbs_pkg::*;
(
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // request channel
  input  logic                        start_i,
  output logic                        busy_o,
  input  logic [VISIT_BITS-1:0]       parent_visits_i,
  input  logic [VISIT_BITS-1:0]       child_visits_i,
  input  logic [TV_W-1:0]             total_value_i,
  input  logic signed [MEAN_W-1:0]    mean_value_i,
  input  logic [PRIOR_W-1:0]          prior_prob_i,
  // result channel
  output logic                        done_o,
  output logic signed [SCORE_W-1:0]   score_o,
  // config write port
  input  logic                        cfg_we_i,
  input  logic [CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]       cfg_wdata_i
);

  // Pipeline stage numbers (stage 0 is the request capture)
  localparam int ST_PREP  = 1;
  localparam int ST_M     = 2;
  localparam int ST_DVS   = 3;
  localparam int ST_ROOT  = ST_PREP + SQ_ROOT_W;
  localparam int ST_C     = ST_ROOT + 1;
  localparam int ST_NUM   = ST_C + 1;
  localparam int ST_EXPL  = ST_NUM + Q_W;
  localparam int ST_FRAC  = ST_M + FRAC_BITS;
  localparam int ST_LN    = ST_FRAC + 1;
  localparam int ST_RATIO = ST_LN + Q_W;
  localparam int ST_RROOT = ST_RATIO + RROOT_W;
  localparam int ST_LOGT  = ST_RROOT + 1;
  localparam int ST_SUM   = ST_LOGT + 1;

  localparam int SUM_W   = SCORE_W + 3;
  localparam int DW_W    = TV_W + WGT_W;
  localparam int LNP_W   = LN_W + LN2_W + 1;
  localparam logic [Q_W-1:0] EXPL_MAX = Q_W'((64'd1 << (SCORE_W-1)) - 64'd1);
  localparam logic [SCORE_W-1:0] EXPL_SAT = SCORE_W'(64'd1 << (SCORE_W-1));
  localparam logic signed [SUM_W-1:0] SUM_HI = SUM_W'((64'd1 << (SCORE_W-1)) - 64'd1);
  localparam logic signed [SUM_W-1:0] SUM_LO = -SUM_W'(64'd1 << (SCORE_W-1));

  logic accept;

  // Config registers
  logic [GAIN_W-1:0]  eg_q;
  logic               scale_q;
  logic [WGT_W-1:0]   lw_q;
  logic [GAIN_W-1:0]  lg_q;
  logic [FRESH_W-1:0] fresh_q;

  // Pipeline payload
  logic [ST_SUM:0]         vld_q;
  logic [VISIT_BITS-1:0]   pv_q;
  logic [TV_W-1:0]         tv_q;
  logic [MEAN_W-1:0]       mean_q;
  logic [VISIT_BITS-1:0]   cv_q    [0:ST_LN];
  logic [PRIOR_W-1:0]      prior_q [0:ST_C];
  logic [FRESH_W-1:0]      base_q  [ST_PREP:ST_LOGT];
  logic [K_W-1:0]          k_q     [ST_PREP:ST_FRAC];
  logic [DV_W-1:0]         dvs_q   [ST_DVS:ST_NUM];
  logic [Q_W-1:0]          expl_q  [ST_EXPL+1:ST_LOGT];
  logic [VISIT_BITS-1:0]   pv1_q;
  logic [TV_W-1:0]         vq_q;
  logic [TV_W-1:0]         vq2_q;
  logic [TV_W-1:0]         d_q;
  logic [WGT_W-1:0]        w_q;
  logic [DW_W-1:0]         dw_q;
  logic [VISIT_BITS-1:0]   m_q;
  logic [C_W-1:0]          c_q;
  logic [NUM_W-1:0]        num_q;
  logic [LN_W-1:0]         ln_q;
  logic [LOGT_W-1:0]       logt_q;
  logic [SCORE_W-1:0]      score_q;

  // Stage 0 to 1 logic
  logic [VISIT_BITS-1:0]   pv1;
  logic [K_W-1:0]          k_msb;
  logic [TV_W-1:0]         vq;
  logic [FRESH_W-1:0]      base;

  // Later stage logic
  logic [DW_W:0]                    dw_rnd;
  logic [GAIN_W+SQ_ROOT_W-1:0]      gain_prod;
  logic [LNP_W-1:0]                 ln_prod;
  logic [GAIN_W+RROOT_W-1:0]        logt_prod;
  logic [SCORE_W-1:0]               expl_sat;
  logic signed [SUM_W-1:0]          sum;

  // Cell chains
  sq_t sqp_c [0:SQ_ROOT_W];
  lg_t lg_c  [0:FRAC_BITS];
  dv_t dve_c [0:Q_W];
  dv_t dvr_c [0:Q_W];
  sq_t sqr_c [0:RROOT_W];

  assign accept = start_i && !busy_o;
  assign busy_o = 1'b0;

  // Config writes; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eg_q    <= GAIN_W'(1) << FRAC_BITS;
      scale_q <= 1'b1;
      lw_q    <= '0;
      lg_q    <= '0;
      fresh_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_EXPLORE_GAIN:    eg_q    <= cfg_wdata_i[GAIN_W-1:0];
        CFG_SCALE_BY_PARENT: scale_q <= cfg_wdata_i[0];
        CFG_LOSS_WEIGHT:     lw_q    <= cfg_wdata_i[WGT_W-1:0];
        CFG_LOG_GAIN:        lg_q    <= cfg_wdata_i[GAIN_W-1:0];
        CFG_FRESH_VALUE:     fresh_q <= cfg_wdata_i[FRESH_W-1:0];
        default: ;
      endcase
    end
  end

  // Request valid tracking
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[ST_SUM-1:0], accept};
    end
  end

  // Stage 0 to 1: parent clamp, leading one, losses operand, base value
  always_comb begin
    pv1   = (pv_q == '0) ? VISIT_BITS'(1) : pv_q;
    k_msb = '0;
    for (int i = 0; i < VISIT_BITS; i++) begin
      if (pv1[i]) begin
        k_msb = K_W'(i);
      end
    end
    vq   = {cv_q[0], FRAC_BITS'(0)};
    base = (cv_q[0] != '0)
         ? {{(FRESH_W-MEAN_W){mean_q[MEAN_W-1]}}, mean_q}
         : fresh_q;
  end

  // Blend divisor rounding and later arithmetic
  always_comb begin
    dw_rnd    = (DW_W+1)'(dw_q) + (DW_W+1)'((64'd1 << FRAC_BITS) - 64'd1);
    gain_prod = (GAIN_W+SQ_ROOT_W)'(eg_q) * (GAIN_W+SQ_ROOT_W)'(sqp_c[SQ_ROOT_W].root);
    ln_prod   = LNP_W'({k_q[ST_FRAC], lg_c[FRAC_BITS].frac}) * LNP_W'(LN2_Q32)
              + LNP_W'(64'd1 << (LN2_W-1));
    logt_prod = (GAIN_W+RROOT_W)'(lg_q)
              * (GAIN_W+RROOT_W)'(sqr_c[RROOT_W].root[RROOT_W-1:0]);
    expl_sat  = (expl_q[ST_LOGT] > EXPL_MAX) ? EXPL_SAT
                                             : expl_q[ST_LOGT][SCORE_W-1:0];
    sum = $signed({{(SUM_W-FRESH_W){base_q[ST_LOGT][FRESH_W-1]}}, base_q[ST_LOGT]})
        + $signed(SUM_W'(expl_sat))
        + $signed(SUM_W'(logt_q));
  end

  // Payload registers and delay lines
  always_ff @(posedge clk_i) begin
    // request capture
    pv_q        <= parent_visits_i;
    cv_q[0]     <= child_visits_i;
    tv_q        <= total_value_i;
    mean_q      <= mean_value_i;
    prior_q[0]  <= prior_prob_i;
    for (int i = 1; i <= ST_LN; i++) begin
      cv_q[i] <= cv_q[i-1];
    end
    for (int i = 1; i <= ST_C; i++) begin
      prior_q[i] <= prior_q[i-1];
    end

    // stage 1
    pv1_q          <= pv1;
    k_q[ST_PREP]   <= k_msb;
    vq_q           <= vq;
    d_q            <= (tv_q < vq) ? tv_q : vq;
    w_q            <= (lw_q > W_ONE) ? W_ONE : lw_q;
    base_q[ST_PREP] <= base;
    for (int i = ST_PREP + 1; i <= ST_FRAC; i++) begin
      k_q[i] <= k_q[i-1];
    end
    for (int i = ST_PREP + 1; i <= ST_LOGT; i++) begin
      base_q[i] <= base_q[i-1];
    end

    // stage 2: normalize mantissa, weight the loss-free part
    m_q   <= pv1_q << (K_W'(VISIT_BITS - 1) - k_q[ST_PREP]);
    dw_q  <= DW_W'(d_q) * DW_W'(w_q);
    vq2_q <= vq_q;

    // stage 3: divider denominator = 1 + blended divisor
    dvs_q[ST_DVS] <= DV_W'(vq2_q) + DV_W'(W_ONE) - DV_W'(dw_rnd >> FRAC_BITS);
    for (int i = ST_DVS + 1; i <= ST_NUM; i++) begin
      dvs_q[i] <= dvs_q[i-1];
    end

    // exploration gain and numerator
    c_q   <= scale_q ? gain_prod[GAIN_W+SQ_ROOT_W-1:FRAC_BITS] : C_W'(eg_q);
    num_q <= NUM_W'(c_q) * NUM_W'(prior_q[ST_C]);

    // exploration quotient aligned to the log term
    expl_q[ST_EXPL+1] <= dve_c[Q_W].q;
    for (int i = ST_EXPL + 2; i <= ST_LOGT; i++) begin
      expl_q[i] <= expl_q[i-1];
    end

    // natural log, round half up
    ln_q   <= ln_prod[LN2_W +: LN_W];
    logt_q <= logt_prod[GAIN_W+RROOT_W-1:FRAC_BITS];

    // final sum with saturation
    if (sum > SUM_HI) begin
      score_q <= SUM_HI[SCORE_W-1:0];
    end else if (sum < SUM_LO) begin
      score_q <= SUM_LO[SCORE_W-1:0];
    end else begin
      score_q <= sum[SCORE_W-1:0];
    end
  end

  // Chain heads
  always_comb begin
    sqp_c[0].rem  = '0;
    sqp_c[0].root = '0;
    sqp_c[0].rad  = {pv1_q, (SQ_RAD_W-VISIT_BITS)'(0)};

    lg_c[0].m    = m_q;
    lg_c[0].frac = '0;

    // top fraction-width bits sit below any denominator, so preload them
    dve_c[0].rem = DV_W'(num_q[NUM_W-1:Q_W]);
    dve_c[0].dd  = num_q[Q_W-1:0];
    dve_c[0].q   = '0;
    dve_c[0].dvs = dvs_q[ST_NUM];

    dvr_c[0].rem = '0;
    dvr_c[0].dd  = Q_W'({ln_q, FRAC_BITS'(0)});
    dvr_c[0].q   = '0;
    dvr_c[0].dvs = DV_W'(cv_q[ST_LN]) + DV_W'(1);

    sqr_c[0].rem  = '0;
    sqr_c[0].root = '0;
    sqr_c[0].rad  = {dvr_c[Q_W].q[2*RROOT_W-1:0], (SQ_RAD_W-2*RROOT_W)'(0)};
  end

  // sqrt(parent visits) in Q.16
  for (genvar g = 0; g < SQ_ROOT_W; g++) begin : g_sqp
    ucbs_sqrt_cell u_cell (.clk_i(clk_i), .sq_i(sqp_c[g]), .sq_o(sqp_c[g+1]));
  end

  // log2 fraction bits
  for (genvar g = 0; g < FRAC_BITS; g++) begin : g_log
    ucbs_log_cell u_cell (.clk_i(clk_i), .lg_i(lg_c[g]), .lg_o(lg_c[g+1]));
  end

  // exploration = c * prior / (1 + divisor)
  for (genvar g = 0; g < Q_W; g++) begin : g_dve
    ucbs_div_cell u_cell (.clk_i(clk_i), .dv_i(dve_c[g]), .dv_o(dve_c[g+1]));
  end

  // ratio = ln / (1 + child visits)
  for (genvar g = 0; g < Q_W; g++) begin : g_dvr
    ucbs_div_cell u_cell (.clk_i(clk_i), .dv_i(dvr_c[g]), .dv_o(dvr_c[g+1]));
  end

  // sqrt(ratio)
  for (genvar g = 0; g < RROOT_W; g++) begin : g_sqr
    ucbs_sqrt_cell u_cell (.clk_i(clk_i), .sq_i(sqr_c[g]), .sq_o(sqr_c[g+1]));
  end

  assign done_o  = vld_q[ST_SUM];
  assign score_o = score_q;

  // Assertions
  `UCBS_ASSERT(a_lat_fwd, accept |-> ##(ST_SUM + 1) done_o, "request lost in pipeline")
  `UCBS_ASSERT(a_lat_bwd, done_o |-> $past(accept, ST_SUM + 1), "score without request")
  `UCBS_ASSERT(a_norm, vld_q[ST_M] |-> m_q[VISIT_BITS-1], "mantissa not normalized")
  `UCBS_ASSERT_NEXT(a_ln_zero, vld_q[ST_FRAC] && (k_q[ST_FRAC] == '0),
                    ln_q == '0, "ln of one not zero")

endmodule

`default_nettype wire
